>>> hw/rtl/dsc_pkg.sv
// Shared constants, codes, types and a helper function of the decimal string calculator.
package dsc_pkg;

    localparam int OPERAND_DIGITS_DEF = 9;
    localparam int OPERAND_W = 36;
    localparam int VAL_W = 30;
    localparam int RES_W = 31;
    localparam int BIN_W = 32;
    localparam int DIG_MAX = 10;
    localparam int BCD_FULL_W = 4 * DIG_MAX;
    localparam int BCD_W = 38;
    localparam int CNT_W = 4;
    localparam int LO_DIGITS = 5;
    localparam int LO_W = 17;
    localparam int HI_W = 14;
    localparam int LO_SCALE = 100000;
    localparam int BITS_PER_STAGE = 4;
    localparam int B2B_STAGES = BIN_W / BITS_PER_STAGE;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_MOD = 3'd4;

    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_NEG  = 3'd1;
    localparam logic [2:0] ST_DIV0 = 3'd2;
    localparam logic [2:0] ST_OVF  = 3'd3;
    localparam logic [2:0] ST_BAD  = 3'd4;

    typedef struct packed {
        logic [2:0]       op;
        logic [2:0]       status;
        logic [RES_W-1:0] r;
    } side_t;

    function automatic logic [3:0] add3(input logic [3:0] d);
        add3 = (d >= 4'd5) ? 4'(d + 4'd3) : d;
    endfunction

endpackage

>>> hw/rtl/dsc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with request sideband.
module dsc_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [dsc_pkg::VAL_W-1:0]  dividend,
    input  logic [dsc_pkg::VAL_W-1:0]  divisor,
    input  dsc_pkg::side_t             in_side,
    output logic                       out_valid,
    output logic [dsc_pkg::VAL_W-1:0]  quot,
    output logic [dsc_pkg::VAL_W-1:0]  rem,
    output dsc_pkg::side_t             out_side
);

    localparam int W = dsc_pkg::VAL_W;

    logic           v_reg [W];
    logic [W-1:0]   q_reg [W];
    logic [W-1:0]   r_reg [W];
    logic [W-1:0]   d_reg [W];
    dsc_pkg::side_t s_reg [W];

    genvar k;
    generate
        for (k = 0; k < W; k++)
        begin : g_stage
            logic           v_in;
            logic [W-1:0]   q_in;
            logic [W-1:0]   r_in;
            logic [W-1:0]   d_in;
            dsc_pkg::side_t s_in;
            logic [W:0]     trial;
            logic           take;
            logic [W-1:0]   r_next;
            logic [W-1:0]   q_next;

            if (k == 0)
            begin : g_first
                assign v_in = in_valid;
                assign q_in = dividend;
                assign r_in = '0;
                assign d_in = divisor;
                assign s_in = in_side;
            end
            else
            begin : g_rest
                assign v_in = v_reg[k-1];
                assign q_in = q_reg[k-1];
                assign r_in = r_reg[k-1];
                assign d_in = d_reg[k-1];
                assign s_in = s_reg[k-1];
            end

            always_comb
            begin
                trial  = {r_in, q_in[W-1]};
                take   = (trial >= {1'b0, d_in});
                r_next = take ? W'(trial - {1'b0, d_in}) : trial[W-1:0];
                q_next = {q_in[W-2:0], take};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else
                begin
                    v_reg[k] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                q_reg[k] <= q_next;
                r_reg[k] <= r_next;
                d_reg[k] <= d_in;
                s_reg[k] <= s_in;
            end
        end
    endgenerate

    assign out_valid = v_reg[W-1];
    assign quot      = q_reg[W-1];
    assign rem       = r_reg[W-1];
    assign out_side  = s_reg[W-1];

endmodule

>>> hw/rtl/dsc_b2b.sv
// Pipelined binary to packed BCD converter with significant digit count.
module dsc_b2b (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [dsc_pkg::RES_W-1:0]   bin,
    input  logic [2:0]                  in_status,
    output logic                        out_valid,
    output logic [dsc_pkg::BCD_W-1:0]   bcd,
    output logic [dsc_pkg::CNT_W-1:0]   digits,
    output logic [2:0]                  out_status
);

    localparam int NS = dsc_pkg::B2B_STAGES;
    localparam int BW = dsc_pkg::BIN_W;
    localparam int FW = dsc_pkg::BCD_FULL_W;

    logic          v_reg   [NS];
    logic [BW-1:0] bin_reg [NS];
    logic [FW-1:0] bcd_reg [NS];
    logic [2:0]    st_reg  [NS];

    genvar k;
    generate
        for (k = 0; k < NS; k++)
        begin : g_stage
            logic          v_in;
            logic [BW-1:0] bin_in;
            logic [FW-1:0] bcd_in;
            logic [2:0]    st_in;
            logic [BW-1:0] bin_next;
            logic [FW-1:0] bcd_next;

            if (k == 0)
            begin : g_first
                assign v_in   = in_valid;
                assign bin_in = {{(BW - dsc_pkg::RES_W){1'b0}}, bin};
                assign bcd_in = '0;
                assign st_in  = in_status;
            end
            else
            begin : g_rest
                assign v_in   = v_reg[k-1];
                assign bin_in = bin_reg[k-1];
                assign bcd_in = bcd_reg[k-1];
                assign st_in  = st_reg[k-1];
            end

            always_comb
            begin
                bin_next = bin_in;
                bcd_next = bcd_in;
                for (int s = 0; s < dsc_pkg::BITS_PER_STAGE; s++)
                begin
                    for (int d = 0; d < dsc_pkg::DIG_MAX; d++)
                    begin
                        bcd_next[4*d +: 4] = dsc_pkg::add3(bcd_next[4*d +: 4]);
                    end
                    bcd_next = {bcd_next[FW-2:0], bin_next[BW-1]};
                    bin_next = {bin_next[BW-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else
                begin
                    v_reg[k] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                bin_reg[k] <= bin_next;
                bcd_reg[k] <= bcd_next;
                st_reg[k]  <= st_in;
            end
        end
    endgenerate

    logic                      out_v_reg;
    logic [dsc_pkg::BCD_W-1:0] bcd_out_reg;
    logic [dsc_pkg::CNT_W-1:0] cnt_out_reg;
    logic [2:0]                st_out_reg;
    logic [dsc_pkg::CNT_W-1:0] cnt_next;

    always_comb
    begin
        cnt_next = dsc_pkg::CNT_W'(1);
        for (int d = 1; d < dsc_pkg::DIG_MAX; d++)
        begin
            if (bcd_reg[NS-1][4*d +: 4] != 4'd0)
            begin
                cnt_next = dsc_pkg::CNT_W'(d + 1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg <= v_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_out_reg <= bcd_reg[NS-1][dsc_pkg::BCD_W-1:0];
        cnt_out_reg <= cnt_next;
        st_out_reg  <= st_reg[NS-1];
    end

    assign out_valid  = out_v_reg;
    assign bcd        = bcd_out_reg;
    assign digits     = cnt_out_reg;
    assign out_status = st_out_reg;

endmodule

>>> hw/rtl/decimal_string_calculator.sv
// Top level of the decimal string calculator: BCD decode, arithmetic and result pipeline.
// The block takes one request in every clock cycle and never raises busy; each request
// gives exactly one result, marked by done for one cycle. A request passes through decode,
// multiply, the 30 stages of the restoring divider, one quotient bit per stage, select
// and the eight stages of the binary to BCD converter. Results leave in
// request order, and since the receiver cannot stall, it must take each one when it comes.
module decimal_string_calculator #(
    parameter int OPERAND_DIGITS = dsc_pkg::OPERAND_DIGITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [2:0]                      op,
    input  logic [dsc_pkg::OPERAND_W-1:0]   operand_a,
    input  logic [dsc_pkg::OPERAND_W-1:0]   operand_b,
    output logic                            done,
    output logic [dsc_pkg::BCD_W-1:0]       result_bcd,
    output logic [dsc_pkg::CNT_W-1:0]       result_digits,
    output logic [2:0]                      status
);

    localparam int VW = dsc_pkg::VAL_W;
    localparam int RW = dsc_pkg::RES_W;

    // Stage 1: digit check and split conversion.
    logic                     v1_reg;
    logic [2:0]               op1_reg;
    logic                     bad1_reg;
    logic [dsc_pkg::LO_W-1:0] alo1_reg, blo1_reg;
    logic [dsc_pkg::HI_W-1:0] ahi1_reg, bhi1_reg;
    logic                     bad_next;
    logic [dsc_pkg::LO_W-1:0] alo_next, blo_next;
    logic [dsc_pkg::HI_W-1:0] ahi_next, bhi_next;

    always_comb
    begin
        bad_next = 1'b0;
        alo_next = '0;
        blo_next = '0;
        ahi_next = '0;
        bhi_next = '0;
        for (int i = dsc_pkg::OPERAND_DIGITS_DEF - 1; i >= 0; i--)
        begin
            if (i < OPERAND_DIGITS)
            begin
                if (operand_a[4*i +: 4] > 4'd9 || operand_b[4*i +: 4] > 4'd9)
                begin
                    bad_next = 1'b1;
                end
                if (i >= dsc_pkg::LO_DIGITS)
                begin
                    ahi_next = dsc_pkg::HI_W'(ahi_next * 4'd10 + operand_a[4*i +: 4]);
                    bhi_next = dsc_pkg::HI_W'(bhi_next * 4'd10 + operand_b[4*i +: 4]);
                end
                else
                begin
                    alo_next = dsc_pkg::LO_W'(alo_next * 4'd10 + operand_a[4*i +: 4]);
                    blo_next = dsc_pkg::LO_W'(blo_next * 4'd10 + operand_b[4*i +: 4]);
                end
            end
        end
    end

    // Stage 2: binary operands.
    logic          v2_reg;
    logic [2:0]    op2_reg;
    logic          bad2_reg;
    logic [VW-1:0] a2_reg, b2_reg;

    // Stage 3: sum and product.
    logic            v3_reg;
    logic [2:0]      op3_reg;
    logic            bad3_reg;
    logic [VW-1:0]   a3_reg, b3_reg;
    logic [RW-1:0]   sum3_reg;
    logic [2*VW-1:0] prod3_reg;

    // Stage 4: status and non-division result.
    logic           v4_reg;
    logic [VW-1:0]  a4_reg, b4_reg;
    dsc_pkg::side_t side4_reg;
    dsc_pkg::side_t side_next;

    always_comb
    begin
        side_next.op     = op3_reg;
        side_next.status = dsc_pkg::ST_OK;
        side_next.r      = '0;
        if (bad3_reg)
        begin
            side_next.status = dsc_pkg::ST_BAD;
        end
        else
        begin
            case (op3_reg)
                dsc_pkg::OP_ADD:
                begin
                    side_next.r = sum3_reg;
                end
                dsc_pkg::OP_SUB:
                begin
                    if (a3_reg < b3_reg)
                    begin
                        side_next.status = dsc_pkg::ST_NEG;
                    end
                    else
                    begin
                        side_next.r = RW'(a3_reg - b3_reg);
                    end
                end
                dsc_pkg::OP_MUL:
                begin
                    if (prod3_reg[2*VW-1:RW] != '0)
                    begin
                        side_next.status = dsc_pkg::ST_OVF;
                    end
                    else
                    begin
                        side_next.r = prod3_reg[RW-1:0];
                    end
                end
                dsc_pkg::OP_DIV, dsc_pkg::OP_MOD:
                begin
                    if (b3_reg == '0)
                    begin
                        side_next.status = dsc_pkg::ST_DIV0;
                    end
                end
                default:
                begin
                    side_next.r = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        op1_reg   <= op;
        bad1_reg  <= bad_next;
        alo1_reg  <= alo_next;
        blo1_reg  <= blo_next;
        ahi1_reg  <= ahi_next;
        bhi1_reg  <= bhi_next;

        op2_reg   <= op1_reg;
        bad2_reg  <= bad1_reg;
        a2_reg    <= VW'(ahi1_reg * dsc_pkg::LO_W'(dsc_pkg::LO_SCALE) + alo1_reg);
        b2_reg    <= VW'(bhi1_reg * dsc_pkg::LO_W'(dsc_pkg::LO_SCALE) + blo1_reg);

        op3_reg   <= op2_reg;
        bad3_reg  <= bad2_reg;
        a3_reg    <= a2_reg;
        b3_reg    <= b2_reg;
        sum3_reg  <= RW'(a2_reg + b2_reg);
        prod3_reg <= a2_reg * b2_reg;

        a4_reg    <= a3_reg;
        b4_reg    <= b3_reg;
        side4_reg <= side_next;
    end

    logic           dv_valid;
    logic [VW-1:0]  dv_quot, dv_rem;
    dsc_pkg::side_t dv_side;

    dsc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .dividend  (a4_reg),
        .divisor   (b4_reg),
        .in_side   (side4_reg),
        .out_valid (dv_valid),
        .quot      (dv_quot),
        .rem       (dv_rem),
        .out_side  (dv_side)
    );

    // Select stage: final binary result.
    logic          v5_reg;
    logic [RW-1:0] r5_reg;
    logic [2:0]    st5_reg;
    logic [RW-1:0] r_sel;

    always_comb
    begin
        case (dv_side.op)
            dsc_pkg::OP_DIV: r_sel = {1'b0, dv_quot};
            dsc_pkg::OP_MOD: r_sel = {1'b0, dv_rem};
            default:         r_sel = dv_side.r;
        endcase
        if (dv_side.status != dsc_pkg::ST_OK)
        begin
            r_sel = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else
        begin
            v5_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        r5_reg  <= r_sel;
        st5_reg <= dv_side.status;
    end

    dsc_b2b u_b2b (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (v5_reg),
        .bin        (r5_reg),
        .in_status  (st5_reg),
        .out_valid  (done),
        .bcd        (result_bcd),
        .digits     (result_digits),
        .out_status (status)
    );

    assign busy = 1'b0;

endmodule

>>> tb/sv/decimal_string_calculator_checker.sv
// Checker for the decimal string calculator: predicts each result and compares it.
module decimal_string_calculator_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [2:0]                    op,
    input  logic [dsc_pkg::OPERAND_W-1:0] operand_a,
    input  logic [dsc_pkg::OPERAND_W-1:0] operand_b,
    input  logic                          done,
    input  logic [dsc_pkg::BCD_W-1:0]     result_bcd,
    input  logic [dsc_pkg::CNT_W-1:0]     result_digits,
    input  logic [2:0]                    status,
    output int                            fail_count,
    output int                            pending,
    output int                            checked
);

    typedef struct packed {
        logic [dsc_pkg::BCD_W-1:0] bcd;
        logic [dsc_pkg::CNT_W-1:0] digits;
        logic [2:0]                st;
    } calc_result_t;

    calc_result_t answer_q[$];

    function automatic logic bcd_to_bin(input logic [dsc_pkg::OPERAND_W-1:0] bcd,
                                        output longint unsigned value);
        logic good;
        logic [3:0] nib;
        good = 1'b1;
        value = 0;
        for (int i = dsc_pkg::OPERAND_DIGITS_DEF - 1; i >= 0; i--)
        begin
            nib = bcd[4*i +: 4];
            if (nib > 4'd9)
            begin
                good = 1'b0;
            end
            value = value * 10 + nib;
        end
        return good;
    endfunction

    function automatic calc_result_t compute_answer(
        input logic [2:0]                    code,
        input logic [dsc_pkg::OPERAND_W-1:0] a_bcd,
        input logic [dsc_pkg::OPERAND_W-1:0] b_bcd
    );
        calc_result_t res;
        longint unsigned a, b, r;
        logic ga, gb;
        logic [2:0] st;
        ga = bcd_to_bin(a_bcd, a);
        gb = bcd_to_bin(b_bcd, b);
        r = 0;
        st = dsc_pkg::ST_OK;
        if (!ga || !gb)
        begin
            st = dsc_pkg::ST_BAD;
        end
        else
        begin
            case (code)
                dsc_pkg::OP_ADD: r = a + b;
                dsc_pkg::OP_SUB:
                begin
                    if (a < b) st = dsc_pkg::ST_NEG;
                    else r = a - b;
                end
                dsc_pkg::OP_MUL: r = a * b;
                dsc_pkg::OP_DIV:
                begin
                    if (b == 0) st = dsc_pkg::ST_DIV0;
                    else r = a / b;
                end
                dsc_pkg::OP_MOD:
                begin
                    if (b == 0) st = dsc_pkg::ST_DIV0;
                    else r = a % b;
                end
                default: r = 0;
            endcase
            if (st == dsc_pkg::ST_OK && r > 64'd2147483647)
            begin
                st = dsc_pkg::ST_OVF;
            end
        end
        if (st != dsc_pkg::ST_OK)
        begin
            r = 0;
        end
        res.bcd = '0;
        res.digits = 0;
        for (int i = 0; i < dsc_pkg::DIG_MAX; i++)
        begin
            res.bcd[4*i +: 4] = 4'(r % 10);
            r = r / 10;
            res.digits++;
            if (r == 0) break;
        end
        res.st = st;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("MISMATCH %s: got %0h expected %0h", what, got, want);
        fail_count++;
    endtask

    assign pending = answer_q.size();

    initial
    begin
        fail_count = 0;
        checked = 0;
    end

    always @(posedge clk)
    begin
        calc_result_t want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                answer_q.push_back(compute_answer(op, operand_a, operand_b));
            end
            if (done)
            begin
                checked++;
                if (answer_q.size() == 0)
                begin
                    report_mismatch("unexpected result", result_bcd, 0);
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (result_bcd !== want.bcd)
                        report_mismatch("result_bcd", result_bcd, want.bcd);
                    if (result_digits !== want.digits)
                        report_mismatch("result_digits", result_digits, want.digits);
                    if (status !== want.st)
                        report_mismatch("status", status, want.st);
                end
            end
        end
    end
endmodule

>>> tb/sv/decimal_string_calculator_tb.sv
// Testbench top for the decimal string calculator: stimulus, watchdog and verdict.
module decimal_string_calculator_tb;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [2:0] op = '0;
    logic [dsc_pkg::OPERAND_W-1:0] operand_a = '0;
    logic [dsc_pkg::OPERAND_W-1:0] operand_b = '0;
    logic busy, done;
    logic [dsc_pkg::BCD_W-1:0] result_bcd;
    logic [dsc_pkg::CNT_W-1:0] result_digits;
    logic [2:0] status;
    int fail_count, pending, checked;
    int idle_pct = 0;
    int quiet = 0;
    int sent = 0;

    always #5 clk = ~clk;

    decimal_string_calculator i_dut (.*);

    decimal_string_calculator_checker i_checker (.*);

    function automatic logic [dsc_pkg::OPERAND_W-1:0] rand_bcd(input int ndig);
        logic [dsc_pkg::OPERAND_W-1:0] v;
        v = '0;
        for (int i = 0; i < ndig; i++)
        begin
            v[4*i +: 4] = 4'($urandom_range(0, 9));
        end
        return v;
    endfunction

    function automatic logic [dsc_pkg::OPERAND_W-1:0] rand_operand();
        int k;
        k = $urandom_range(0, 99);
        if (k < 3) return dsc_pkg::OPERAND_W'({$urandom, $urandom});
        if (k < 8) return '0;
        if (k < 12) return {9{4'd9}};
        return rand_bcd($urandom_range(1, 9));
    endfunction

    task automatic send_request(input logic [2:0] code,
                                input logic [dsc_pkg::OPERAND_W-1:0] a,
                                input logic [dsc_pkg::OPERAND_W-1:0] b);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        op <= code;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (busy) @(posedge clk);
        sent++;
    endtask

    always @(posedge clk)
    begin
        if ((start && !busy) || done) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > 5000)
        begin
            $display("decimal_string_calculator test failed");
            $finish;
        end
    end

    initial
    begin
        logic [dsc_pkg::OPERAND_W-1:0] nine;
        nine = {9{4'd9}};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int c = 0; c < 8; c++) send_request(3'(c), 36'h000000123, 36'h000000045);
        send_request(dsc_pkg::OP_ADD, nine, nine);
        send_request(dsc_pkg::OP_ADD, 36'h000000000, 36'h000000000);
        send_request(dsc_pkg::OP_ADD, 36'h000000000, 36'h147483647);
        send_request(dsc_pkg::OP_ADD, 36'h000000001, 36'h147483647);
        send_request(dsc_pkg::OP_SUB, 36'h000000005, 36'h000000007);
        send_request(dsc_pkg::OP_SUB, nine, nine);
        send_request(dsc_pkg::OP_MUL, nine, nine);
        send_request(dsc_pkg::OP_MUL, 36'h000046341, 36'h000046340);
        send_request(dsc_pkg::OP_DIV, nine, 36'h000000000);
        send_request(dsc_pkg::OP_MOD, nine, 36'h000000000);
        send_request(dsc_pkg::OP_DIV, nine, 36'h000000001);
        send_request(dsc_pkg::OP_MOD, nine, 36'h000000007);
        send_request(dsc_pkg::OP_ADD, 36'h00000000A, 36'h000000001);
        send_request(dsc_pkg::OP_ADD, 36'h000000001, 36'hF00000000);
        send_request(dsc_pkg::OP_ADD, 36'hFFFFFFFFF, 36'hFFFFFFFFF);
        send_request(dsc_pkg::OP_SUB, 36'h000000001, 36'hA00000000);
        send_request(dsc_pkg::OP_ADD, 36'h000000001, 36'h000000002);
        start <= 1'b0;
        while (pending != 0) @(posedge clk);
        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct = (phase == 0) ? 0 : (phase == 3 ? 9 : 63);
            for (int n = 0; n < 185; n++)
            begin
                logic [dsc_pkg::OPERAND_W-1:0] a, b;
                logic [2:0] code;
                code = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                   : 3'($urandom_range(0, 4));
                a = rand_operand();
                b = rand_operand();
                if (code == dsc_pkg::OP_MUL && $urandom_range(0, 1))
                begin
                    a = rand_bcd($urandom_range(1, 5));
                    b = rand_bcd($urandom_range(1, 4));
                end
                send_request(code, a, b);
            end
            start <= 1'b0;
            @(posedge clk);
        end
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        $display("Sent %0d requests and checked %0d results over all ops,", sent, checked);
        $display("error statuses and four idle phases.");
        if (fail_count == 0 && pending == 0) $display("decimal_string_calculator test passed");
        else $display("decimal_string_calculator test failed");
        $finish;
    end
endmodule
